// ===== design/fhws_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fhws_pkg - shared types and constants of the frame hop window scheduler
// Field widths, command and status codes, sequencer states, divider request.
// ----------------------------------------------------------------------------
package fhws_pkg;

	// Index width actually used out of the 32-bit index fields
	localparam int INDEX_BITS = 32;
	localparam int IDX_W      = 32;
	localparam int LEN_W      = 16;
	localparam int CNT_W      = 32;

	// Largest representable index, on one extra bit for non-wrapping sums
	localparam logic [IDX_W:0]   IDX_MAX  = (33'd1 << INDEX_BITS) - 33'd1;
	localparam logic [IDX_W-1:0] IDX_MASK = IDX_MAX[IDX_W-1:0];

	// Shared divider: 33-bit dividend, hop-wide divisor, one bit per cycle
	localparam int DIV_W      = IDX_W + 1;
	localparam int DIV_CNT_W  = $clog2(DIV_W);

	// Configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 1;
	localparam logic [REG_IDX_W-1:0] REG_FRAME = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_HOP   = 1'd1;

	typedef enum logic [1:0] {
		OP_UPDATE = 2'd0,
		OP_SEEK   = 2'd1,
		OP_POP    = 2'd2,
		OP_RESET  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BUSY       = 2'd1,
		ST_ZERO_FRAME = 2'd2,
		ST_REFUSED    = 2'd3
	} status_t;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_CMD   = 9'b000000010,
		S_UPD   = 9'b000000100,
		S_RDY   = 9'b000001000,
		S_SKIP  = 9'b000010000,
		S_BLSET = 9'b000100000,
		S_BLW   = 9'b001000000,
		S_PEAK  = 9'b010000000,
		S_OUT   = 9'b100000000
	} seq_state_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [LEN_W-1:0] divisor;
	} div_req_t;

	// Cut an index field to the configured index width
	function automatic logic [IDX_W-1:0] mask_idx(input logic [IDX_W-1:0] v);
		return v & IDX_MASK;
	endfunction

endpackage
`default_nettype wire

// ===== design/fhws_cmd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fhws_cmd_if - command channel of the frame hop window scheduler
// Valid/ready channel carrying one scheduler command per transfer.
// ----------------------------------------------------------------------------
interface fhws_cmd_if import fhws_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       opcode;
	logic [IDX_W-1:0] total_written;
	logic [IDX_W-1:0] oldest_index;
	logic             view_ok;

	modport source (output valid, opcode, total_written, oldest_index, view_ok,
		input ready);
	modport sink (input valid, opcode, total_written, oldest_index, view_ok,
		output ready);
endinterface
`default_nettype wire

// ===== design/fhws_res_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fhws_res_if - result channel of the frame hop window scheduler
// Valid/ready channel carrying one result per command.
// ----------------------------------------------------------------------------
interface fhws_res_if import fhws_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic [IDX_W-1:0] window_start;
	logic [LEN_W-1:0] window_length;
	logic             ready_res;
	logic [CNT_W-1:0] backlog;
	logic [CNT_W-1:0] max_backlog;
	logic             jump;
	logic             clamped;
	logic [IDX_W-1:0] clamp_delta;
	logic [CNT_W-1:0] skipped_hops;
	logic [CNT_W-1:0] clamp_count;
	logic [CNT_W-1:0] pop_count;

	modport source (output valid, status, window_start, window_length, ready_res,
		backlog, max_backlog, jump, clamped, clamp_delta, skipped_hops,
		clamp_count, pop_count, input ready);
	modport sink (input valid, status, window_start, window_length, ready_res,
		backlog, max_backlog, jump, clamped, clamp_delta, skipped_hops,
		clamp_count, pop_count, output ready);
endinterface
`default_nettype wire

// ===== design/frame_hop_window_scheduler_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frame_hop_window_scheduler_unit - overlapping frame/hop window scheduler
// Tracks window starts over a ring buffer's absolute sample index.
// ----------------------------------------------------------------------------
// Usage:
//   cmd is a valid/ready channel carrying opcode (update, seek, pop, reset),
//   total_written, oldest_index and view_ok; res returns exactly one result
//   per command. frame_length and hop_length are written over the APB port
//   (byte addresses 0 and 4) while no command is in flight.
//   One command is worked at a time: cmd.ready is high only when idle. A
//   command steps through the sequencer states to res.valid; without a
//   division a reset or a pop that hands out nothing passes the fewest, a
//   seek more and an update or a successful pop the most. The backlog
//   division and, after a clamp, the skipped-hop ceiling division each hold
//   the command until the divider is done. Both divisions share one restoring
//   divider that produces one quotient bit per cycle (33 steps).
//   The result is held on res until transferred; a stalled receiver simply
//   holds the block, and the next command is taken the cycle after.
//   arst_n clears the registers to zero and all scheduler state; the reset
//   opcode clears the scheduler state but keeps the registers.
// ----------------------------------------------------------------------------
module frame_hop_window_scheduler_unit import fhws_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	fhws_cmd_if.sink              cmd,
	fhws_res_if.source            res,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic [LEN_W-1:0] frame;
	logic [LEN_W-1:0] hop;
	div_req_t         div_req;
	logic             div_done;
	logic [DIV_W-1:0] div_quo;

	// Configuration registers
	fhws_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.frame   (frame),
		.hop     (hop)
	);

	// Shared divider
	fhws_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Command sequencer
	fhws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.res      (res),
		.frame    (frame),
		.hop      (hop),
		.div_req  (div_req),
		.div_done (div_done),
		.div_quo  (div_quo)
	);

endmodule
`default_nettype wire

// ===== design/fhws_apb_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fhws_apb_regs - configuration registers
// APB-style write/read of frame length and hop length.
// ----------------------------------------------------------------------------
module fhws_apb_regs import fhws_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [LEN_W-1:0]      frame,
	output logic [LEN_W-1:0]      hop
);

	logic [REG_IDX_W-1:0] idx;
	logic                 wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[APB_ADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite & pready;

	// Write the selected register on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame <= '0;
			hop   <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_FRAME: frame <= pwdata[LEN_W-1:0];
				REG_HOP:   hop   <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (idx)
			REG_FRAME: prdata = APB_DATA_W'(frame);
			REG_HOP:   prdata = APB_DATA_W'(hop);
			default:   prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ===== design/fhws_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fhws_div - shared restoring divider
// One quotient bit per cycle; quotient valid with done.
// ----------------------------------------------------------------------------
module fhws_div import fhws_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  div_req_t         req,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	logic [LEN_W-1:0]     rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [LEN_W-1:0]     div_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [LEN_W:0]       shifted;
	logic                 fits;

	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

	// Trial subtract of the divisor from the shifted partial remainder
	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign fits    = shifted >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			div_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				rem_q  <= '0;
				quo_q  <= req.dividend;
				div_q  <= req.divisor;
				cnt_q  <= DIV_LAST;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? LEN_W'(shifted - {1'b0, div_q}) : shifted[LEN_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

// ===== design/fhws_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fhws_ctrl - command sequencer and scheduler state
// Steps one command through clamp, readiness, skip and backlog divisions and
// peak tracking, then holds the result until it is taken.
// ----------------------------------------------------------------------------
module fhws_ctrl import fhws_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	fhws_cmd_if.sink          cmd,
	fhws_res_if.source        res,
	input  logic [LEN_W-1:0]  frame,
	input  logic [LEN_W-1:0]  hop,
	output div_req_t          div_req,
	input  logic              div_done,
	input  logic [DIV_W-1:0]  div_quo
);

	seq_state_t       state_q;

	// Scheduler state
	logic [IDX_W-1:0] ns_q;
	logic [IDX_W-1:0] ws_q;
	logic             rdy_q;
	logic [IDX_W-1:0] lps_q;
	logic [CNT_W-1:0] pops_q;
	logic [CNT_W-1:0] clamps_q;
	logic [CNT_W-1:0] peak_q;

	// Latched command
	op_t              op_q;
	logic [IDX_W-1:0] tot_q;
	logic [IDX_W-1:0] old_q;
	logic             vok_q;

	// Result under construction
	status_t          status_q;
	logic [LEN_W-1:0] wlen_q;
	logic             jump_q;
	logic             clamped_q;
	logic [IDX_W-1:0] delta_q;
	logic [CNT_W-1:0] skip_q;
	logic [CNT_W-1:0] bl_q;
	logic [IDX_W-1:0] pstart_q;
	logic             popped_q;
	logic             note_q;
	logic             seek_q;

	logic [IDX_W:0]   end_c;
	logic             fit_c;
	logic             bl_go_c;
	logic [IDX_W-1:0] seek_base_c;
	logic [IDX_W-1:0] seek_start_c;
	logic [IDX_W:0]   adv_c;
	logic [IDX_W-1:0] adv_sat_c;
	logic             jump_c;
	logic             rdy_eff_c;
	logic             hop_nz;
	logic             frame_nz;

	assign hop_nz   = hop != '0;
	assign frame_nz = frame != '0;

	// Window end and readiness against the stored snapshot
	assign end_c   = {1'b0, ns_q} + (IDX_W + 1)'(frame);
	assign fit_c   = frame_nz && (end_c <= {1'b0, ws_q});
	assign bl_go_c = frame_nz && hop_nz && (end_c <= {1'b0, ws_q});

	// Seek target: newest complete window, not behind the oldest sample
	assign seek_base_c  = (tot_q > IDX_W'(frame)) ? tot_q - IDX_W'(frame) : '0;
	assign seek_start_c = (seek_base_c < old_q) ? old_q : seek_base_c;

	// Pop advance with saturation, and hop jump detection
	assign adv_c     = {1'b0, ns_q} + (IDX_W + 1)'(hop);
	assign adv_sat_c = (adv_c > IDX_MAX) ? IDX_MAX[IDX_W-1:0] : adv_c[IDX_W-1:0];
	assign jump_c    = (pops_q != '0) && hop_nz &&
		({1'b0, ns_q} != ({1'b0, lps_q} + (IDX_W + 1)'(hop)));
	assign rdy_eff_c = rdy_q | fit_c;

	// Divider requests: ceiling skip count, then backlog quotient
	always_comb begin
		div_req.divisor = hop;
		if (state_q == S_RDY) begin
			div_req.start    = clamped_q && hop_nz;
			div_req.dividend = DIV_W'(delta_q) + DIV_W'(hop) - DIV_W'(1);
		end else begin
			div_req.start    = (state_q == S_BLSET) && bl_go_c;
			div_req.dividend = DIV_W'(ws_q - end_c[IDX_W-1:0]);
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ns_q      <= '0;
			ws_q      <= '0;
			rdy_q     <= 1'b0;
			lps_q     <= '0;
			pops_q    <= '0;
			clamps_q  <= '0;
			peak_q    <= '0;
			op_q      <= OP_UPDATE;
			tot_q     <= '0;
			old_q     <= '0;
			vok_q     <= 1'b0;
			status_q  <= ST_OK;
			wlen_q    <= '0;
			jump_q    <= 1'b0;
			clamped_q <= 1'b0;
			delta_q   <= '0;
			skip_q    <= '0;
			bl_q      <= '0;
			pstart_q  <= '0;
			popped_q  <= 1'b0;
			note_q    <= 1'b0;
			seek_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						op_q      <= op_t'(cmd.opcode);
						tot_q     <= mask_idx(cmd.total_written);
						old_q     <= mask_idx(cmd.oldest_index);
						vok_q     <= cmd.view_ok;
						status_q  <= ST_OK;
						wlen_q    <= '0;
						jump_q    <= 1'b0;
						clamped_q <= 1'b0;
						delta_q   <= '0;
						skip_q    <= '0;
						popped_q  <= 1'b0;
						note_q    <= 1'b0;
						seek_q    <= 1'b0;
						state_q   <= S_CMD;
					end
				end
				S_CMD: begin
					case (op_q)
						OP_UPDATE: begin
							note_q  <= 1'b1;
							state_q <= S_UPD;
						end
						OP_SEEK: begin
							ws_q    <= tot_q;
							ns_q    <= frame_nz ? seek_start_c : old_q;
							note_q  <= 1'b1;
							seek_q  <= 1'b1;
							state_q <= S_RDY;
						end
						OP_RESET: begin
							ns_q     <= '0;
							ws_q     <= '0;
							rdy_q    <= 1'b0;
							lps_q    <= '0;
							pops_q   <= '0;
							clamps_q <= '0;
							peak_q   <= '0;
							state_q  <= S_BLSET;
						end
						OP_POP: begin
							if (!frame_nz) begin
								status_q <= ST_ZERO_FRAME;
								state_q  <= S_BLSET;
							end else if (!rdy_eff_c) begin
								status_q <= ST_BUSY;
								state_q  <= S_BLSET;
							end else if (!vok_q) begin
								rdy_q    <= 1'b1;
								status_q <= ST_REFUSED;
								state_q  <= S_BLSET;
							end else begin
								// Hand out the window and advance one hop
								pstart_q <= ns_q;
								popped_q <= 1'b1;
								wlen_q   <= frame;
								jump_q   <= jump_c;
								pops_q   <= pops_q + 1'b1;
								lps_q    <= ns_q;
								ns_q     <= adv_sat_c;
								rdy_q    <= 1'b0;
								note_q   <= 1'b1;
								state_q  <= S_UPD;
							end
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_UPD: begin
					// Clamp a start that fell behind the oldest held sample
					ws_q <= tot_q;
					if (ns_q < old_q) begin
						clamps_q  <= clamps_q + 1'b1;
						clamped_q <= 1'b1;
						delta_q   <= old_q - ns_q;
						ns_q      <= old_q;
					end
					state_q <= S_RDY;
				end
				S_RDY: begin
					if (seek_q) begin
						rdy_q <= fit_c;
					end else if (fit_c) begin
						rdy_q <= 1'b1;
					end
					state_q <= (clamped_q && hop_nz) ? S_SKIP : S_BLSET;
				end
				S_SKIP: begin
					if (div_done) begin
						skip_q  <= div_quo[CNT_W-1:0];
						state_q <= S_BLSET;
					end
				end
				S_BLSET: begin
					if (bl_go_c) begin
						state_q <= S_BLW;
					end else begin
						bl_q    <= '0;
						state_q <= S_PEAK;
					end
				end
				S_BLW: begin
					if (div_done) begin
						bl_q    <= div_quo[CNT_W-1:0] + 1'b1;
						state_q <= S_PEAK;
					end
				end
				S_PEAK: begin
					if (note_q && (bl_q > peak_q)) begin
						peak_q <= bl_q;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (res.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Channel handshakes and result fields
	assign cmd.ready         = state_q == S_IDLE;
	assign res.valid         = state_q == S_OUT;
	assign res.status        = status_q;
	assign res.window_start  = popped_q ? pstart_q : ns_q;
	assign res.window_length = wlen_q;
	assign res.ready_res     = rdy_q;
	assign res.backlog       = bl_q;
	assign res.max_backlog   = peak_q;
	assign res.jump          = jump_q;
	assign res.clamped       = clamped_q;
	assign res.clamp_delta   = delta_q;
	assign res.skipped_hops  = skip_q;
	assign res.clamp_count   = clamps_q;
	assign res.pop_count     = pops_q;

endmodule
`default_nettype wire

// ===== design/fhws_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fhws_checker - port-level checks of the window scheduler
// Bound to the top level; watches the command and result channels.
// ----------------------------------------------------------------------------
module fhws_checker import fhws_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             cmd_valid,
	input logic             cmd_ready,
	input logic             res_valid,
	input logic             res_ready,
	input logic [1:0]       status,
	input logic [LEN_W-1:0] window_length,
	input logic             jump,
	input logic             clamped,
	input logic [IDX_W-1:0] clamp_delta,
	input logic [CNT_W-1:0] skipped_hops
);

	// One command in flight: never take a command while a result is offered
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd_ready && res_valid))
		else $error("command accepted while a result is pending");

	// A taken command makes the block busy until its result is out
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> !cmd_ready)
		else $error("block still ready after a command transfer");

	// After a result transfer the block is free for the next command
	a_free_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready) |=> cmd_ready)
		else $error("block not ready after result transfer");

	// Only a successful pop carries a window length or a hop jump
	a_pop_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && status != ST_OK) |-> (window_length == '0 && !jump))
		else $error("window fields set on a failed command");

	// A clamp always skips samples; no clamp skips nothing
	a_clamp_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((clamped == (clamp_delta != '0)) &&
			(clamped || skipped_hops == '0)))
		else $error("clamp fields inconsistent");

endmodule

bind frame_hop_window_scheduler_unit fhws_checker u_fhws_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd.valid),
	.cmd_ready     (cmd.ready),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.status        (res.status),
	.window_length (res.window_length),
	.jump          (res.jump),
	.clamped       (res.clamped),
	.clamp_delta   (res.clamp_delta),
	.skipped_hops  (res.skipped_hops)
);
`default_nettype wire
